// File: rtl/jhd_pkg.sv
// ----------------------------------------------------------------------------
// jhd_pkg
// Shared types and constants for the JPEG Huffman block decoder.
// ----------------------------------------------------------------------------
package jhd_pkg;

  localparam int NUM_TABLES_DEF        = 4;
  localparam int MAX_CODE_LENGTH       = 16;
  localparam int SYMBOLS_PER_TABLE_DEF = 256;
  localparam int MAX_BLOCK_DEF         = 64;
  localparam int QUEUE_DEPTH           = 4;

  // input kind codes
  localparam logic [1:0] KIND_COUNT  = 2'd0;
  localparam logic [1:0] KIND_SYMBOL = 2'd1;
  localparam logic [1:0] KIND_BIT    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_CODE = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  localparam logic [6:0] BLOCK_LENGTH_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_SYMBOL,
    OP_BIT
  } op_t;

  typedef enum logic [1:0] {
    PH_DC,
    PH_AC,
    PH_MAG
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CNT,
    BK_SYM
  } bk_state_t;

  // one classified item in the queue
  typedef struct packed {
    op_t        op;
    logic       cls;
    logic [1:0] tid;
    logic [7:0] idx;
    logic [7:0] val;
    logic       bit_in;
    logic [1:0] dct;
    logic [1:0] act;
  } q_item_t;

endpackage

// File: rtl/jpeg_huffman_block_decoder.sv
// ----------------------------------------------------------------------------
// jpeg_huffman_block_decoder
// Bit-serial JPEG baseline Huffman decoder for one block per run.
// ----------------------------------------------------------------------------
// Usage:
//  s_* takes load beats (count and symbol entries of the canonical tables)
//  and entropy bits, one per beat; s_tuser carries the kind. m_* gives one
//  beat per decoded coefficient, m_tlast marks the last of a block and
//  m_tuser carries the status. cfg_we/cfg_wdata write block_length.
//  A four-entry queue parts the input side from the decode side, so input
//  keeps flowing while a result waits at the output register.
//  Loads and magnitude bits are handled in BK_IDLE alone; a Huffman code
//  bit also passes BK_CNT (count store read), and BK_SYM as well when it
//  completes a code (symbol store read). BK_CNT and BK_SYM wait while the
//  output beat has not been taken. Loads and ignored beats give no result.
//  Reset clears the decode state and sets block_length to 64; the table
//  stores hold nothing until loaded. If m_tready is low, decoding holds at
//  the next result and the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module jpeg_huffman_block_decoder #(
  parameter int NUM_TABLES        = jhd_pkg::NUM_TABLES_DEF,
  parameter int SYMBOLS_PER_TABLE = jhd_pkg::SYMBOLS_PER_TABLE_DEF,
  parameter int MAX_BLOCK         = jhd_pkg::MAX_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // table_class, table_id[2:1], load_index[10:3], load_value[18:11],
  // data_bit[19], dc_table[21:20], ac_table[23:22]
  input  logic [23:0] s_tdata,
  // kind
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // coefficient[15:0], position[21:16], zero pad
  output logic [23:0] m_tdata,
  // block_end
  output logic        m_tlast,
  // status
  output logic [1:0]  m_tuser
);
  import jhd_pkg::*;

  q_item_t push_item, q_item;
  logic    q_full, q_push, q_valid, pop;

  jhd_front #(
    .NUM_TABLES(NUM_TABLES),
    .SYMBOLS_PER_TABLE(SYMBOLS_PER_TABLE)
  ) u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .q_full(q_full),
    .q_push(q_push),
    .q_item(push_item)
  );

  jhd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_item(push_item),
    .full(q_full),
    .pop(pop),
    .q_valid(q_valid),
    .q_item(q_item)
  );

  jhd_back #(
    .NUM_TABLES(NUM_TABLES),
    .SYMBOLS_PER_TABLE(SYMBOLS_PER_TABLE),
    .MAX_BLOCK(MAX_BLOCK)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid(q_valid),
    .q_item(q_item),
    .pop(pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

endmodule

// File: rtl/jhd_front.sv
// ----------------------------------------------------------------------------
// jhd_front
// Accepts input beats, drops ignored ones and classifies the rest.
// ----------------------------------------------------------------------------
module jhd_front #(
  parameter int NUM_TABLES        = jhd_pkg::NUM_TABLES_DEF,
  parameter int SYMBOLS_PER_TABLE = jhd_pkg::SYMBOLS_PER_TABLE_DEF
) (
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             q_full,
  output logic             q_push,
  output jhd_pkg::q_item_t q_item
);
  import jhd_pkg::*;

  logic keep;

  assign s_tready = !q_full;

  // unpack and classify
  always_comb begin
    q_item.cls    = s_tdata[0];
    q_item.tid    = s_tdata[2:1];
    q_item.idx    = s_tdata[10:3];
    q_item.val    = s_tdata[18:11];
    q_item.bit_in = s_tdata[19];
    q_item.dct    = s_tdata[21:20];
    q_item.act    = s_tdata[23:22];
    q_item.op     = OP_BIT;
    keep          = 1'b0;
    case (s_tuser)
      KIND_COUNT: begin
        q_item.op = OP_COUNT;
        keep = (int'(s_tdata[2:1]) < NUM_TABLES) && (int'(s_tdata[10:3]) < MAX_CODE_LENGTH);
      end
      KIND_SYMBOL: begin
        q_item.op = OP_SYMBOL;
        keep = (int'(s_tdata[2:1]) < NUM_TABLES)
            && (int'(s_tdata[10:3]) < SYMBOLS_PER_TABLE);
      end
      KIND_BIT: begin
        q_item.op = OP_BIT;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = s_tvalid && !q_full && keep;

endmodule

// File: rtl/jhd_queue.sv
// ----------------------------------------------------------------------------
// jhd_queue
// Small FIFO between front and back.
// ----------------------------------------------------------------------------
module jhd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jhd_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output jhd_pkg::q_item_t q_item
);
  import jhd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  q_item_t     mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   fill;

  assign full    = (fill == (PW+1)'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_item  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// File: rtl/jhd_back.sv
// ----------------------------------------------------------------------------
// jhd_back
// Table stores, bit-serial canonical decode and the output register.
// ----------------------------------------------------------------------------
module jhd_back #(
  parameter int NUM_TABLES        = jhd_pkg::NUM_TABLES_DEF,
  parameter int SYMBOLS_PER_TABLE = jhd_pkg::SYMBOLS_PER_TABLE_DEF,
  parameter int MAX_BLOCK         = jhd_pkg::MAX_BLOCK_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata,
  input  logic             q_valid,
  input  jhd_pkg::q_item_t q_item,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,
  output logic             m_tlast,
  output logic [1:0]       m_tuser
);
  import jhd_pkg::*;

  localparam int CNT_DEPTH = 2 * NUM_TABLES * MAX_CODE_LENGTH;
  localparam int CAW       = $clog2(CNT_DEPTH);
  localparam int SYM_DEPTH = 2 * NUM_TABLES * SYMBOLS_PER_TABLE;
  localparam int SAW       = $clog2(SYM_DEPTH);
  localparam int TBW       = $clog2(2 * NUM_TABLES);

  // table memories
  logic [7:0]     cnt_mem [CNT_DEPTH];
  logic [7:0]     sym_mem [SYM_DEPTH];
  logic [7:0]     cnt_rd, sym_rd;
  logic [CAW-1:0] cnt_waddr, cnt_raddr;
  logic [SAW-1:0] sym_waddr, sym_raddr;
  logic           cnt_we, sym_we;

  // decode state
  bk_state_t   st, st_next;
  phase_t      phase, phase_next;
  logic [15:0] code_accum, code_accum_next;
  logic [16:0] first_code, first_code_next;
  logic [8:0]  symbol_base, symbol_base_next;
  logic [4:0]  code_length, code_length_next;
  logic [7:0]  pending, pending_next;
  logic [14:0] mag, mag_next;
  logic [3:0]  bits_left, bits_left_next;
  logic [6:0]  pos, pos_next;
  logic [1:0]  dc_sel, dc_sel_next, ac_sel, ac_sel_next;
  logic [TBW-1:0] tbl_q, tbl_q_next;
  logic [6:0]  block_length;

  // output register
  logic        o_valid_next;
  logic [15:0] coef, coef_next;
  logic [5:0]  opos, opos_next;
  logic        oend, oend_next;
  logic [1:0]  ostat, ostat_next;

  logic        out_free;
  logic        do_finish, do_fail, end_blk;
  logic [1:0]  fail_st;
  logic [15:0] fin_value;
  logic [6:0]  eff_len;

  // table selection reduced to the table count by compare and subtract
  function automatic logic [1:0] tbl_mod(logic [1:0] sel);
    logic [1:0] r;
    r = sel;
    for (int i = 0; i < 3; i++) begin
      if (int'(r) >= NUM_TABLES) r = r - 2'(NUM_TABLES);
    end
    return r;
  endfunction

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (st == BK_IDLE) && q_valid && out_free;

  assign m_tdata = {2'b00, opos, coef};
  assign m_tlast = oend;
  assign m_tuser = ostat;

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= q_item.val;
    cnt_rd <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_waddr] <= q_item.val;
    sym_rd <= sym_mem[sym_raddr];
  end

  assign cnt_waddr = CAW'((int'(q_item.cls) * NUM_TABLES + int'(q_item.tid))
                          * MAX_CODE_LENGTH + int'(q_item.idx[3:0]));
  assign sym_waddr = SAW'((int'(q_item.cls) * NUM_TABLES + int'(q_item.tid))
                          * SYMBOLS_PER_TABLE + int'(q_item.idx));
  assign cnt_we = pop && (q_item.op == OP_COUNT);
  assign sym_we = pop && (q_item.op == OP_SYMBOL);

  // effective block length, saturated to 1..MAX_BLOCK
  always_comb begin
    if (block_length == 7'd0) eff_len = 7'd1;
    else if (int'(block_length) > MAX_BLOCK) eff_len = 7'(MAX_BLOCK);
    else eff_len = block_length;
  end

  // decode step
  always_comb begin
    logic [TBW-1:0] tbl;
    logic [16:0]    diff;
    logic [9:0]     sidx;
    logic [18:0]    fc_sum;
    logic [9:0]     sb_sum;
    logic [3:0]     size;
    logic [16:0]    v;
    logic [3:0]     run;
    logic [3:0]     sz;
    logic [6:0]     target;
    logic [6:0]     tplus;

    st_next          = st;
    phase_next       = phase;
    code_accum_next  = code_accum;
    first_code_next  = first_code;
    symbol_base_next = symbol_base;
    code_length_next = code_length;
    pending_next     = pending;
    mag_next         = mag;
    bits_left_next   = bits_left;
    pos_next         = pos;
    dc_sel_next      = dc_sel;
    ac_sel_next      = ac_sel;
    tbl_q_next       = tbl_q;
    o_valid_next     = m_tvalid && !m_tready;
    coef_next        = coef;
    opos_next        = opos;
    oend_next        = oend;
    ostat_next       = ostat;
    cnt_raddr        = '0;
    sym_raddr        = '0;
    do_finish        = 1'b0;
    do_fail          = 1'b0;
    fail_st          = ST_OK;
    fin_value        = '0;
    end_blk          = 1'b0;
    tbl              = '0;
    diff             = '0;
    sidx             = '0;
    fc_sum           = '0;
    sb_sum           = '0;
    size             = '0;
    v                = '0;
    run              = '0;
    sz               = '0;
    target           = '0;
    tplus            = '0;

    case (st)
      BK_IDLE: begin
        if (pop && q_item.op == OP_BIT) begin
          if (phase == PH_MAG) begin
            // magnitude bit, MSB first
            mag_next       = {mag[13:0], q_item.bit_in};
            bits_left_next = bits_left - 4'd1;
            if (bits_left_next == 4'd0) begin
              size = pending[3:0];
              v    = {2'b00, mag_next};
              if ((mag_next >> (size - 4'd1)) == 15'd0)
                v = v - ((17'd1 << size) - 17'd1);
              do_finish = 1'b1;
              fin_value = v[15:0];
            end
          end else begin
            // code bit: latch tables at block start, fetch count
            if (phase == PH_DC && code_length == 5'd0) begin
              dc_sel_next = tbl_mod(q_item.dct);
              ac_sel_next = tbl_mod(q_item.act);
            end
            tbl = (phase == PH_DC) ? TBW'(dc_sel_next)
                                   : TBW'(NUM_TABLES + int'(ac_sel_next));
            code_accum_next  = {code_accum[14:0], q_item.bit_in};
            code_length_next = code_length + 5'd1;
            cnt_raddr  = CAW'(int'(tbl) * MAX_CODE_LENGTH + int'(code_length[3:0]));
            tbl_q_next = tbl;
            st_next    = BK_CNT;
          end
        end
      end
      BK_CNT: begin
        if (out_free) begin
          diff = {1'b0, code_accum} - first_code;
          if ({1'b0, code_accum} >= first_code && diff < {9'd0, cnt_rd}) begin
            sidx = {1'b0, symbol_base} + {2'b00, diff[7:0]};
            if (int'(sidx) >= SYMBOLS_PER_TABLE) begin
              do_fail = 1'b1;
              fail_st = ST_NO_CODE;
              st_next = BK_IDLE;
            end else begin
              sym_raddr = SAW'(int'(tbl_q) * SYMBOLS_PER_TABLE + int'(sidx));
              st_next   = BK_SYM;
            end
          end else begin
            fc_sum = ({2'b00, first_code} + {11'd0, cnt_rd}) << 1;
            first_code_next = (fc_sum > 19'h1FFFF) ? 17'h1FFFF : fc_sum[16:0];
            sb_sum = {1'b0, symbol_base} + {2'b00, cnt_rd};
            symbol_base_next = (sb_sum > 10'd511) ? 9'd511 : sb_sum[8:0];
            if (code_length >= 5'd16) begin
              do_fail = 1'b1;
              fail_st = ST_NO_CODE;
            end
            st_next = BK_IDLE;
          end
        end
      end
      BK_SYM: begin
        if (out_free) begin
          code_accum_next  = '0;
          first_code_next  = '0;
          symbol_base_next = '0;
          code_length_next = '0;
          pending_next     = sym_rd;
          st_next          = BK_IDLE;
          if (phase == PH_DC && sym_rd[7:4] != 4'd0) begin
            do_fail = 1'b1;
            fail_st = ST_NO_CODE;
          end else if (sym_rd[3:0] == 4'd0) begin
            do_finish = 1'b1;
            fin_value = '0;
          end else begin
            bits_left_next = sym_rd[3:0];
            mag_next       = '0;
            phase_next     = PH_MAG;
          end
        end
      end
      default: st_next = BK_IDLE;
    endcase

    // coefficient completion and block termination
    if (do_fail) begin
      o_valid_next = 1'b1;
      coef_next    = '0;
      opos_next    = pos[5:0];
      oend_next    = 1'b1;
      ostat_next   = fail_st;
      end_blk      = 1'b1;
    end else if (do_finish) begin
      if (pos == 7'd0) begin
        o_valid_next = 1'b1;
        coef_next    = fin_value;
        opos_next    = '0;
        oend_next    = (eff_len <= 7'd1);
        ostat_next   = ST_OK;
        if (eff_len <= 7'd1) end_blk = 1'b1;
        else begin
          pos_next   = 7'd1;
          phase_next = PH_AC;
        end
      end else begin
        run    = pending_next[7:4];
        sz     = pending_next[3:0];
        target = pos + {3'd0, run};
        tplus  = target + 7'd1;
        o_valid_next = 1'b1;
        if (sz == 4'd0 && run != 4'hF) begin
          coef_next  = '0;
          opos_next  = pos[5:0];
          oend_next  = 1'b1;
          ostat_next = ST_OK;
          end_blk    = 1'b1;
        end else if (target >= eff_len) begin
          coef_next  = '0;
          opos_next  = pos[5:0];
          oend_next  = 1'b1;
          ostat_next = ST_OVERRUN;
          end_blk    = 1'b1;
        end else begin
          coef_next  = fin_value;
          opos_next  = target[5:0];
          oend_next  = (tplus >= eff_len);
          ostat_next = ST_OK;
          if (tplus >= eff_len) end_blk = 1'b1;
          else begin
            pos_next   = tplus;
            phase_next = PH_AC;
          end
        end
      end
    end

    if (end_blk) begin
      code_accum_next  = '0;
      first_code_next  = '0;
      symbol_base_next = '0;
      code_length_next = '0;
      mag_next         = '0;
      bits_left_next   = '0;
      pos_next         = '0;
      phase_next       = PH_DC;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= BK_IDLE;
      phase        <= PH_DC;
      code_accum   <= '0;
      first_code   <= '0;
      symbol_base  <= '0;
      code_length  <= '0;
      pending      <= '0;
      mag          <= '0;
      bits_left    <= '0;
      pos          <= '0;
      dc_sel       <= '0;
      ac_sel       <= '0;
      tbl_q        <= '0;
      m_tvalid     <= 1'b0;
      block_length <= BLOCK_LENGTH_RESET;
    end else begin
      st           <= st_next;
      phase        <= phase_next;
      code_accum   <= code_accum_next;
      first_code   <= first_code_next;
      symbol_base  <= symbol_base_next;
      code_length  <= code_length_next;
      pending      <= pending_next;
      mag          <= mag_next;
      bits_left    <= bits_left_next;
      pos          <= pos_next;
      dc_sel       <= dc_sel_next;
      ac_sel       <= ac_sel_next;
      tbl_q        <= tbl_q_next;
      m_tvalid     <= o_valid_next;
      if (cfg_we) block_length <= cfg_wdata;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    coef  <= coef_next;
    opos  <= opos_next;
    oend  <= oend_next;
    ostat <= ostat_next;
  end

endmodule

// File: tb/jhd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jhd_checker
// Watches the load/bit input stream and the coefficient output stream of the
// JPEG Huffman block decoder. It keeps its own copy of the tables and the
// decode state and predicts every coefficient beat. Each output beat is then
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module jhd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tlast,
  input  logic [1:0]  m_tuser,
  output int          errors,
  output int          pending
);
  import jhd_pkg::*;

  typedef struct packed {
    logic [15:0] coef;
    logic [5:0]  pos;
    logic        last;
    logic [1:0]  st;
  } coef_beat_t;

  coef_beat_t coef_q[$];
  int         err_cnt = 0;

  // table mirror
  logic [7:0] len_counts[0:127];
  logic [7:0] sym_bytes[0:2047];

  // decode state
  int unsigned code_acc, code_first, code_base, code_len;
  int unsigned pend_sym, mag_acc, mag_left, coef_pos, blk_len, dc_pick, ac_pick;
  phase_t      phase;

  assign errors = err_cnt;

  function automatic int unsigned eff_len();
    if (blk_len < 1) return 1;
    if (blk_len > 64) return 64;
    return blk_len;
  endfunction

  task automatic clear_code();
    code_acc = 0; code_first = 0; code_base = 0; code_len = 0;
  endtask

  task automatic close_block();
    clear_code();
    mag_acc = 0; mag_left = 0; coef_pos = 0;
    phase = PH_DC;
  endtask

  task automatic push_coef(int v, int unsigned p, bit last, logic [1:0] st);
    coef_beat_t b;
    b.coef = v[15:0];
    b.pos  = p[5:0];
    b.last = last;
    b.st   = st;
    coef_q.push_back(b);
  endtask

  task automatic abort_block(logic [1:0] st);
    push_coef(0, coef_pos, 1'b1, st);
    close_block();
  endtask

  // a finished coefficient; DC when at position 0
  task automatic place_coef(int v);
    int unsigned len, run, sz, target;
    len = eff_len();
    if (coef_pos == 0) begin
      push_coef(v, 0, len <= 1, ST_OK);
      if (len <= 1) close_block();
      else begin
        coef_pos = 1;
        phase = PH_AC;
      end
      return;
    end
    run = (pend_sym >> 4) & 4'hF;
    sz = pend_sym & 4'hF;
    target = coef_pos + run;
    if (sz == 0 && run != 15) begin
      push_coef(0, coef_pos, 1'b1, ST_OK);
      close_block();
      return;
    end
    if (target >= len) begin
      abort_block(ST_OVERRUN);
      return;
    end
    coef_pos = target + 1;
    push_coef(v, target, coef_pos >= len, ST_OK);
    if (coef_pos >= len) close_block();
    else phase = PH_AC;
  endtask

  // one entropy bit
  task automatic decode_bit(bit b, int unsigned dct, int unsigned act);
    int unsigned tbl, cnt, idx, sym, sz;
    int v;
    if (phase == PH_MAG) begin
      mag_acc = ((mag_acc << 1) | b) & 32'h7FFF;
      mag_left = (mag_left - 1) & 4'hF;
      if (mag_left != 0) return;
      sz = (coef_pos == 0) ? pend_sym : (pend_sym & 4'hF);
      v = int'(mag_acc);
      if ((mag_acc >> (sz - 1)) == 0) v -= int'((1 << sz) - 1);
      place_coef(v);
      return;
    end
    // table selection latched at the first bit of a block
    if (phase == PH_DC && code_len == 0) begin
      dc_pick = dct % 4;
      ac_pick = act % 4;
    end
    tbl = (phase == PH_DC) ? dc_pick : 4 + ac_pick;
    code_acc = ((code_acc << 1) | b) & 32'hFFFF;
    code_len++;
    cnt = len_counts[tbl * 16 + code_len - 1];
    if (code_acc >= code_first && code_acc - code_first < cnt) begin
      idx = code_base + (code_acc - code_first);
      if (idx >= 256) begin
        abort_block(ST_NO_CODE);
        return;
      end
      sym = sym_bytes[tbl * 256 + idx];
      clear_code();
      pend_sym = sym;
      sz = (phase == PH_DC) ? sym : (sym & 4'hF);
      if (sz > 15) begin
        abort_block(ST_NO_CODE);
        return;
      end
      if (sz == 0) begin
        place_coef(0);
        return;
      end
      mag_left = sz;
      mag_acc = 0;
      phase = PH_MAG;
      return;
    end
    code_first = (code_first + cnt) << 1;
    if (code_first > 32'h1FFFF) code_first = 32'h1FFFF;
    code_base += cnt;
    if (code_base > 511) code_base = 511;
    if (code_len >= 16) abort_block(ST_NO_CODE);
  endtask

  // watch both streams
  always @(posedge clk) begin
    int unsigned t;
    coef_beat_t want;
    if (rst) begin
      close_block();
      pend_sym = 0; dc_pick = 0; ac_pick = 0;
      blk_len = BLOCK_LENGTH_RESET;
      coef_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) blk_len = cfg_wdata;
      if (s_tvalid && s_tready) begin
        t = s_tdata[0] * 4 + s_tdata[2:1];
        case (s_tuser)
          KIND_COUNT: begin
            if (s_tdata[10:3] < 16) len_counts[t * 16 + s_tdata[10:3]] = s_tdata[18:11];
          end
          KIND_SYMBOL: begin
            sym_bytes[t * 256 + s_tdata[10:3]] = s_tdata[18:11];
          end
          KIND_BIT: begin
            decode_bit(s_tdata[19], s_tdata[21:20], s_tdata[23:22]);
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (coef_q.size() == 0) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < 10)
            $display("%0t: unexpected beat coef=%0d pos=%0d last=%0b st=%0d", $realtime,
                     $signed(m_tdata[15:0]), m_tdata[21:16], m_tlast, m_tuser);
        end else begin
          want = coef_q.pop_front();
          if (want.coef !== m_tdata[15:0] || want.pos !== m_tdata[21:16] ||
              want.last !== m_tlast || want.st !== m_tuser) begin
            err_cnt <= err_cnt + 1;
            if (err_cnt < 10)
              $display("%0t: mismatch exp coef=%0d pos=%0d last=%0b st=%0d, got %0d %0d %0b %0d",
                       $realtime, $signed(want.coef), want.pos, want.last, want.st,
                       $signed(m_tdata[15:0]), m_tdata[21:16], m_tlast, m_tuser);
          end
        end
      end
      pending <= coef_q.size();
    end
  end

endmodule

// File: tb/jpeg_huffman_block_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jpeg_huffman_block_decoder_tb
// Loads random canonical Huffman tables and streams encoded blocks through
// the decoder, bit by bit, across several block_length settings. Invalid
// codes, overruns, ignored beats and table reloads are mixed in. A checker
// predicts and compares every coefficient beat; this module drives stimulus
// and flow control and reports the verdict.
// ----------------------------------------------------------------------------
module jpeg_huffman_block_decoder_tb;
  import jhd_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  int          errors;
  int          pending;
  int unsigned cycle = 0;
  int unsigned idle_cyc = 0;
  logic        hold_go = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  // generator's view of the tables and the block length
  logic [7:0]  cnt_m[8][16];
  logic [7:0]  sym_m[8][256];
  int          nsym_m[8];
  int          blen_m = 64;
  int          nbits = 0;
  logic [1:0]  cur_dc, cur_ac;
  bit          first_bit = 0;

  jpeg_huffman_block_decoder u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  jhd_checker u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic bit quiet();
    return cycle >= 150 && cycle < 650;
  endfunction

  // receiver: random stalls, one long hold on request
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet() || ($urandom_range(99) >= 26);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [23:0] pk(logic cls, logic [1:0] tid, logic [7:0] li,
                                     logic [7:0] lv, logic b, logic [1:0] dc, logic [1:0] ac);
    return {ac, dc, b, lv, li, tid, cls};
  endfunction

  function automatic logic [23:0] rand_beat();
    return 24'($urandom());
  endfunction

  task automatic send(logic [1:0] kind, logic [23:0] d);
    while (!quiet() && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= d;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_cnt(int t, logic [7:0] li, logic [7:0] v);
    logic [23:0] r;
    r = rand_beat();
    send(KIND_COUNT, pk(t[2], t[1:0], li, v, r[19], r[21:20], r[23:22]));
    if (li < 16) cnt_m[t][li] = v;
  endtask

  task automatic load_sym(int t, logic [7:0] li, logic [7:0] v);
    logic [23:0] r;
    r = rand_beat();
    send(KIND_SYMBOL, pk(t[2], t[1:0], li, v, r[19], r[21:20], r[23:22]));
    sym_m[t][li] = v;
  endtask

  task automatic send_bit(logic b);
    logic [23:0] r;
    r = rand_beat();
    r[19] = b;
    if (first_bit) begin
      r[21:20] = cur_dc;
      r[23:22] = cur_ac;
      first_bit = 0;
    end
    send(KIND_BIT, r);
    nbits++;
  endtask

  // random canonical table with free space left at the top of every length
  task automatic build_table(int t);
    int avail, rem, maxc, c, n;
    logic [7:0] v;
    avail = 2;
    n = $urandom_range(2, 12);
    rem = n;
    for (int l = 0; l < 16; l++) begin
      maxc = (avail - 1 < rem) ? avail - 1 : rem;
      c = (l == 15) ? maxc : $urandom_range(0, maxc);
      rem -= c;
      avail = (avail - c) * 2;
      load_cnt(t, 8'(l), 8'(c));
    end
    nsym_m[t] = n - rem;
    for (int k = 0; k < nsym_m[t]; k++) begin
      if (t < 4) begin
        if ($urandom_range(19) == 0) v = 8'($urandom_range(16, 255));
        else if ($urandom_range(5) == 0) v = 8'($urandom_range(12, 15));
        else v = 8'($urandom_range(0, 11));
      end else if (k == 0) v = 8'h00;
      else if (k == 1 && $urandom_range(1)) v = 8'hF0;
      else begin
        v[7:4] = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        v[3:0] = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                          : 4'($urandom_range(1, 10));
      end
      load_sym(t, 8'(k), v);
    end
    // harmless write into the unused upper part of the symbol list
    load_sym(t, 8'($urandom_range(128, 255)), 8'($urandom_range(255)));
  endtask

  task automatic send_code(int t, int k);
    int code, idx, len;
    code = 0; idx = 0; len = 0;
    for (int l = 1; l <= 16 && len == 0; l++) begin
      for (int c = 0; c < cnt_m[t][l-1] && len == 0; c++) begin
        if (idx == k) len = l;
        else begin
          code++; idx++;
        end
      end
      if (len == 0) code = code << 1;
    end
    for (int i = len - 1; i >= 0; i--) send_bit(code[i]);
  endtask

  task automatic send_mag(int sz);
    for (int i = 0; i < sz; i++) send_bit(1'($urandom_range(1)));
  endtask

  task automatic bad_code();
    for (int i = 0; i < 16; i++) send_bit(1'b1);
  endtask

  // one block, well formed except for the odd invalid code, DC symbol or overrun
  task automatic gen_block();
    int t, k, pos, run, sz, target;
    logic [7:0] sym;
    cur_dc = 2'($urandom_range(3));
    cur_ac = 2'($urandom_range(3));
    first_bit = 1;
    t = cur_dc;
    if ($urandom_range(24) == 0) begin
      bad_code();
      return;
    end
    k = $urandom_range(nsym_m[t] - 1);
    send_code(t, k);
    sym = sym_m[t][k];
    if (sym > 15) return;
    send_mag(sym);
    pos = 1;
    if (blen_m <= 1) return;
    t = 4 + cur_ac;
    forever begin
      if ($urandom_range(29) == 0) begin
        bad_code();
        return;
      end
      k = $urandom_range(nsym_m[t] - 1);
      send_code(t, k);
      sym = sym_m[t][k];
      run = sym[7:4];
      sz = sym[3:0];
      if (sz == 0 && run != 15) return;
      send_mag(sz);
      target = pos + run;
      if (target >= blen_m) return;
      pos = target + 1;
      if (pos >= blen_m) return;
    end
  endtask

  // sender pauses until every result is back and the block has drained
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_len(logic [6:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    blen_m = (v < 1) ? 1 : (v > 64) ? 64 : v;
  endtask

  initial begin
    logic [6:0] lens[8];
    int target;
    lens = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd5, 7'd64, 7'd0};
    lens[7] = 7'($urandom_range(3, 63));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // symbol index running past the table: 255 codes of 8 bits then 2 of 9
    for (int l = 0; l < 16; l++)
      load_cnt(3, 8'(l), (l == 7) ? 8'd255 : (l == 8) ? 8'd2 : 8'd0);
    cur_dc = 2'd3; cur_ac = 2'd0; first_bit = 1;
    repeat (9) send_bit(1'b1);
    // ignored beats: unused kind, count index past the lengths
    send(2'd3, rand_beat());
    load_cnt(1, 8'd200, 8'hFF);

    for (int t = 0; t < 8; t++) build_table(t);
    // invalid code at DC
    cur_dc = 2'd0; first_bit = 1;
    bad_code();
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_len(lens[ph]);
      if (ph == 3) hold_go <= 1'b1;
      target = nbits + 40;
      while (nbits < target) begin
        gen_block();
        case ($urandom_range(19))
          0: build_table(int'($urandom_range(7)));
          1: repeat ($urandom_range(1, 3)) send_bit(1'($urandom_range(1)));
          2: send(2'd3, rand_beat());
          3: load_cnt(int'($urandom_range(7)), 8'($urandom_range(16, 255)),
                      8'($urandom_range(255)));
          default: ;
        endcase
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
